// ----- rtl/core/lirc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lirc_pkg
// shared types and constants of the linear interpolation rate converter
// ---------------------------------------------------------------------------
package lirc_pkg;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int STEP_W     = 20;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

  typedef enum logic [0:0] {
    REG_STEP_RATIO = 1'b0,
    REG_MONO_MODE  = 1'b1
  } reg_idx_t;

  // queues between front, back and result side
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_status_t;

  // command kinds handed from front to back
  typedef enum logic [0:0] {
    CMD_PRIME = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_kind_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

endpackage

// ----- rtl/core/lirc_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lirc_fifo
// small register queue with status struct, read data shown at the head
// ---------------------------------------------------------------------------
module lirc_fifo #(
  parameter int WIDTH = 33
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   rd_en,
  output logic [WIDTH-1:0]       rd_data,
  output lirc_pkg::fifo_status_t status
);
  import lirc_pkg::*;

  logic [WIDTH-1:0]      mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign do_wr = wr_en && (count != FIFO_CNT_W'(FIFO_DEPTH));
  assign do_rd = rd_en && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  assign rd_data      = mem[rd_ptr];
  assign status.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

// ----- rtl/core/lirc_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lirc_front
// takes source frames, applies mono mode and tags the priming frame
// ---------------------------------------------------------------------------
module lirc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                         mono_mode,
  input  lirc_pkg::fifo_status_t       cmd_status,
  output logic                         full,
  output logic                         cmd_wr,
  output logic [2*SAMPLE_BITS:0]       cmd_data
);
  import lirc_pkg::*;

  logic                   primed;
  logic                   accept;
  cmd_kind_t              kind;
  logic [SAMPLE_BITS-1:0] chan_r;

  assign full   = cmd_status.full;
  assign accept = push && !cmd_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (accept) begin
      primed <= 1'b1;
    end
  end

  // first frame after reset only loads the previous frame
  assign kind     = primed ? CMD_FRAME : CMD_PRIME;
  assign chan_r   = mono_mode ? left_sample : right_sample;
  assign cmd_wr   = accept;
  assign cmd_data = {kind, left_sample, chan_r};

endmodule

// ----- rtl/core/lirc_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lirc_back
// interpolation engine: position stepping, multiply stage, rounding stage
// ---------------------------------------------------------------------------
module lirc_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int MAX_RUN     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lirc_pkg::STEP_W-1:0]   step_ratio,
  input  logic [2*SAMPLE_BITS:0]        cmd_data,
  input  lirc_pkg::fifo_status_t        cmd_status,
  output logic                          cmd_rd,
  input  lirc_pkg::fifo_status_t        out_status,
  output logic                          out_wr,
  output logic [2*SAMPLE_BITS:0]        out_data
);
  import lirc_pkg::*;

  localparam int POS_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 2;
  localparam int PROD_W  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int N_W     = $clog2(MAX_RUN);
  localparam int MIN_INT = ((1 << FRAC_BITS) + MAX_RUN - 1) / MAX_RUN;
  localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0]  MIN_STEP = POS_W'(MIN_INT);
  localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [N_W-1:0]    LAST_N   = N_W'(MAX_RUN - 1);

  back_state_t state, state_next;

  logic [POS_W-1:0]              frac;
  logic [N_W-1:0]                n;
  logic signed [SAMPLE_BITS-1:0] prev_l, prev_r, cur_l, cur_r;

  logic                          s1_valid, s1_last;
  logic signed [SAMPLE_BITS-1:0] s1_a_l, s1_a_r;
  logic signed [PROD_W-1:0]      s1_prod_l, s1_prod_r;

  cmd_kind_t                     cmd_kind;
  logic signed [SAMPLE_BITS-1:0] cmd_l, cmd_r;
  logic [POS_W-1:0]              step_ext, eff_step, frac_sum;
  logic                          room, issue, run_last, fetch;
  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [FRAC_BITS:0]     pos;
  logic signed [PROD_W-1:0]      rnd_l, rnd_r, shf_l, shf_r;
  logic [SAMPLE_BITS-1:0]        res_l, res_r;

  assign cmd_kind = cmd_kind_t'(cmd_data[2*SAMPLE_BITS]);
  assign cmd_l    = cmd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign cmd_r    = cmd_data[SAMPLE_BITS-1:0];

  // steps below the minimum are raised so a run cannot exceed MAX_RUN
  assign step_ext = POS_W'(step_ratio);
  assign eff_step = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
  assign frac_sum = frac + eff_step;
  assign run_last = (frac_sum >= ONE_POS) || (n == LAST_N);

  // leave space for the word in the multiply stage and this one
  assign room = (FIFO_CNT_W'(out_status.count) + FIFO_CNT_W'(s1_valid) + 1'b1)
                <= FIFO_CNT_W'(FIFO_DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_status.empty && cmd_kind == CMD_FRAME && frac < ONE_POS) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (room && run_last) state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    fetch = 1'b0;
    issue = 1'b0;
    unique case (state)
      BK_IDLE: fetch = !cmd_status.empty;
      BK_RUN:  issue = room;
    endcase
  end

  assign cmd_rd = fetch;

  assign diff_l = {cur_l[SAMPLE_BITS-1], cur_l} - {prev_l[SAMPLE_BITS-1], prev_l};
  assign diff_r = {cur_r[SAMPLE_BITS-1], cur_r} - {prev_r[SAMPLE_BITS-1], prev_r};
  assign pos    = {1'b0, frac[FRAC_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      frac     <= '0;
      n        <= '0;
      prev_l   <= '0;
      prev_r   <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      if (fetch) begin
        n <= '0;
        priority if (cmd_kind == CMD_PRIME) begin
          prev_l <= cmd_l;
          prev_r <= cmd_r;
        end else if (frac >= ONE_POS) begin
          // source frame skipped
          frac   <= frac - ONE_POS;
          prev_l <= cmd_l;
          prev_r <= cmd_r;
        end else begin
          // run starts, previous frame kept until its last word
        end
      end
      if (issue) begin
        n <= n + 1'b1;
        if (run_last) begin
          frac   <= (frac_sum >= ONE_POS) ? frac_sum - ONE_POS : frac_sum;
          prev_l <= cur_l;
          prev_r <= cur_r;
        end else begin
          frac <= frac_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      cur_l <= cmd_l;
      cur_r <= cmd_r;
    end
    if (issue) begin
      s1_last   <= run_last;
      s1_a_l    <= prev_l;
      s1_a_r    <= prev_r;
      s1_prod_l <= PROD_W'(diff_l * pos);
      s1_prod_r <= PROD_W'(diff_r * pos);
    end
  end

  // round to nearest, ties upward: floor((d*pos + half) / 2^frac_bits)
  assign rnd_l = s1_prod_l + $signed(HALF);
  assign rnd_r = s1_prod_r + $signed(HALF);
  assign shf_l = rnd_l >>> FRAC_BITS;
  assign shf_r = rnd_r >>> FRAC_BITS;
  assign res_l = s1_a_l + shf_l[SAMPLE_BITS-1:0];
  assign res_r = s1_a_r + shf_r[SAMPLE_BITS-1:0];

  assign out_wr   = s1_valid;
  assign out_data = {s1_last, res_l, res_r};

endmodule

// ----- rtl/core/linear_interp_rate_converter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_interp_rate_converter
// stereo sample-rate converter by linear interpolation with a carried
// fractional read position
// ---------------------------------------------------------------------------
//
//  channel   handshake            words
//  -------   ------------------   ----------------------------------------
//  input     push / full          left_sample, right_sample
//  result    pop / empty          out_left, out_right, last_of_run
//  config    apb psel / penable   step_ratio (0x0), mono_mode (0x4)
//
//  a frame occupies the back end for a dispatch step and then for its
//  results, up to MAX_RUN of them; results stream at one per cycle while
//  the result queue has room, passing the multiply and rounding stages
//  reset (rst, synchronous) empties both queues and clears the position,
//  the previous frame and the priming flag; no clearing pass
//  four-word queues sit on both sides of the engine; a stalled pop only
//  stalls the engine once the result queue, with the word in the multiply
//  stage, would fill, and full only rises when the command queue fills
//
module linear_interp_rate_converter #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int MAX_RUN     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // source frames
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_BITS-1:0]     left_sample,
  input  logic signed [SAMPLE_BITS-1:0]     right_sample,
  // interpolated words
  input  logic                              pop,
  output logic                              empty,
  output logic signed [SAMPLE_BITS-1:0]     out_left,
  output logic signed [SAMPLE_BITS-1:0]     out_right,
  output logic                              last_of_run,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lirc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lirc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lirc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lirc_pkg::*;

  localparam int CMD_W = 2 * SAMPLE_BITS + 1;

  // configuration registers
  logic [STEP_W-1:0] step_ratio;
  logic              mono_mode;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  // queue wiring
  logic         cmd_wr, cmd_rd, out_wr;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata, out_wdata, out_rdata;
  fifo_status_t cmd_status, out_status;
  logic         out_rd;

  // register decode, one word per 4 bytes
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RESET;
      mono_mode  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEP_RATIO: step_ratio <= pwdata[STEP_W-1:0];
        REG_MONO_MODE:  mono_mode  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STEP_RATIO: prdata = CFG_DATA_W'(step_ratio);
      REG_MONO_MODE:  prdata = CFG_DATA_W'(mono_mode);
    endcase
  end

  // front: accept, mono select, mark priming frame
  lirc_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .mono_mode    (mono_mode),
    .cmd_status   (cmd_status),
    .full         (full),
    .cmd_wr       (cmd_wr),
    .cmd_data     (cmd_wdata)
  );

  // command queue between front and back
  lirc_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wdata),
    .rd_en   (cmd_rd),
    .rd_data (cmd_rdata),
    .status  (cmd_status)
  );

  // back: position stepping and interpolation
  lirc_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_RUN     (MAX_RUN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .step_ratio (step_ratio),
    .cmd_data   (cmd_rdata),
    .cmd_status (cmd_status),
    .cmd_rd     (cmd_rd),
    .out_status (out_status),
    .out_wr     (out_wr),
    .out_data   (out_wdata)
  );

  // result queue, head word drives the result ports
  assign out_rd = pop && !out_status.empty;

  lirc_fifo #(
    .WIDTH (CMD_W)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .rd_en   (out_rd),
    .rd_data (out_rdata),
    .status  (out_status)
  );

  assign empty       = out_status.empty;
  assign last_of_run = out_rdata[2*SAMPLE_BITS];
  assign out_left    = out_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign out_right   = out_rdata[SAMPLE_BITS-1:0];

  // engine never writes into a full result queue
  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_status.full)
    else $error("result queue written while full");

  // an accepted frame is waiting in the command queue on the next cycle
  a_cmd_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !cmd_status.empty)
    else $error("accepted frame missing from command queue");

  // reset leaves no stale result visible
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

// ----- verif/lirc_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lirc_scoreboard_pkg
// predictor and result checker for the linear interpolation rate converter
// ---------------------------------------------------------------------------
package lirc_scoreboard_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int RUN_MAX    = 32;
  localparam int POS_W      = 24;
  localparam int ONE_POS    = 1 << FRAC_W;
  localparam int STEP_FLOOR = (ONE_POS + RUN_MAX - 1) / RUN_MAX;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_l;
    logic signed [SAMPLE_W-1:0] out_r;
    logic                       last;
  } audio_word_t;

  class interp_scoreboard;
    // shadow of the registers
    logic [lirc_pkg::STEP_W-1:0] step;
    logic                        mono;
    // shadow of the engine state
    logic signed [SAMPLE_W-1:0]  prev_l;
    logic signed [SAMPLE_W-1:0]  prev_r;
    logic [POS_W-1:0]            frac;
    logic                        primed;

    audio_word_t                 expected_words[$];
    int                          errors;

    function new();
      step   = lirc_pkg::STEP_RESET;
      mono   = 1'b0;
      prev_l = '0;
      prev_r = '0;
      frac   = '0;
      primed = 1'b0;
      errors = 0;
    endfunction

    function void set_step(logic [31:0] data);
      step = data[lirc_pkg::STEP_W-1:0];
    endfunction

    function void set_mono(logic [31:0] data);
      mono = data[0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // a + (b - a) * pos, round to nearest with ties upward (floor of +half)
    function automatic logic [SAMPLE_W-1:0] interp(longint a, longint b, longint pos);
      longint acc;
      acc = (b - a) * pos + longint'(ONE_POS / 2);
      return SAMPLE_W'(a + (acc >>> FRAC_W));
    endfunction

    // one accepted source frame: queue every word it produces
    function void note_frame(logic signed [SAMPLE_W-1:0] l_in,
                             logic signed [SAMPLE_W-1:0] r_in);
      logic signed [SAMPLE_W-1:0] cur_l;
      logic signed [SAMPLE_W-1:0] cur_r;
      logic [POS_W-1:0]           eff;
      audio_word_t                w;
      int                         n;
      cur_l = l_in;
      cur_r = mono ? l_in : r_in;
      eff   = (step < STEP_FLOOR) ? POS_W'(STEP_FLOOR) : POS_W'(step);
      if (!primed) begin
        primed = 1'b1;
        prev_l = cur_l;
        prev_r = cur_r;
        return;
      end
      n = 0;
      while (frac < ONE_POS && n < RUN_MAX) begin
        w.out_l = interp(prev_l, cur_l, frac);
        w.out_r = interp(prev_r, cur_r, frac);
        frac    = frac + eff;
        n++;
        w.last  = (frac >= ONE_POS) || (n == RUN_MAX);
        expected_words.push_back(w);
      end
      if (frac >= ONE_POS) frac = frac - POS_W'(ONE_POS);
      prev_l = cur_l;
      prev_r = cur_r;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic signed [SAMPLE_W-1:0] got_l,
                    logic signed [SAMPLE_W-1:0] got_r,
                    logic                       got_last);
      audio_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word l=%0d r=%0d last=%0b", got_l, got_r, got_last));
        return;
      end
      w = expected_words.pop_front();
      if (got_l !== w.out_l)
        report($sformatf("out_left got %0d expected %0d", got_l, w.out_l));
      if (got_r !== w.out_r)
        report($sformatf("out_right got %0d expected %0d", got_r, w.out_r));
      if (got_last !== w.last)
        report($sformatf("last_of_run got %0b expected %0b", got_last, w.last));
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// regression for the linear interpolation rate converter: directed frames at
// the register and sample extremes, then randomized phases under varying
// step ratio, mono mode, source gaps and result stalls, every word checked
// against a scoreboard prediction
// ---------------------------------------------------------------------------
module tb_top;
  import lirc_pkg::*;
  import lirc_scoreboard_pkg::*;

  localparam int ADDR_W      = CFG_ADDR_W;
  // worst drain: four queued frames, a full run and the result pipe
  localparam int SETTLE      = 80;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 43;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       push         = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] left_sample  = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic                       pop          = 1'b0;
  logic                       empty;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       last_of_run;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [ADDR_W-1:0]          paddr        = '0;
  logic [CFG_DATA_W-1:0]      pwdata       = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  interp_scoreboard           sb;
  int                         send_idle_pct = 0;
  int                         stall_pct     = 0;
  int                         cycle_count   = 0;
  logic signed [SAMPLE_W-1:0] last_l        = '0;
  logic signed [SAMPLE_W-1:0] last_r        = '0;

  linear_interp_rate_converter uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .pop          (pop),
    .empty        (empty),
    .out_left     (out_left),
    .out_right    (out_right),
    .last_of_run  (last_of_run),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("linear_interp_rate_converter regression: fail");
    $finish;
  end

  // result side: check the word taken at this edge, then pick pop for the
  // next one; values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_word(out_left, out_right, last_of_run);
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // one source frame; returns right after the edge that took it, with push
  // still high so a back-to-back frame needs no second assignment
  task send_frame(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (full);
    sb.note_frame(l, r);
    last_l = l;
    last_r = r;
  endtask

  // stop sending and wait until every expected word is out; the extra
  // cycles cover frames that make no word but may still be in flight
  task wait_idle(input int extra);
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_STEP_RATIO) sb.set_step(data);
    else sb.set_mono(data);
    @(posedge clk);
  endtask

  // sample source: mostly full-scale noise, some smooth steps, some extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] near);
    logic [SAMPLE_W-1:0] bits;
    bits = SAMPLE_W'($urandom());
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2: return near + SAMPLE_W'($signed($urandom_range(512)) - 256);
      default: return bits;
    endcase
  endfunction

  // step ratio per phase: extremes, below the floor, above the range, in range
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(7))
      0: return STEP_W'(2048);
      1: return STEP_W'(524288);
      2: return STEP_W'($urandom_range(2047));
      3: return STEP_W'($urandom_range(20'hfffff, 524289));
      4: return STEP_W'($urandom_range(65536, 2048));
      5: return STEP_W'($urandom_range(524288, 65536));
      default: return STEP_W'($urandom_range(524288, 2048));
    endcase
  endfunction

  task run_phase(input int items, input int idle, input int stall);
    int k;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (k = 0; k < items; k++) begin
      // hold off once per phase until the result side has caught up
      if (k == items / 2) wait_idle(0);
      send_frame(pick_sample(last_l), pick_sample(last_r));
    end
    wait_idle(SETTLE);
  endtask

  initial begin
    int i;
    int ph;
    logic [31:0] junk;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // priming frame gives no word, then unit step repeats the previous frame
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd1, 16'sd1);
    wait_idle(SETTLE);

    // smallest step: full runs across the widest swing
    write_reg(REG_STEP_RATIO, 32'd2048);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, -16'sd32768);
    wait_idle(SETTLE);

    // zero step gets raised to the floor
    write_reg(REG_STEP_RATIO, 32'd0);
    send_frame(16'sd12345, -16'sd12345);
    wait_idle(SETTLE);

    // 1.5: runs of one or zero words
    write_reg(REG_STEP_RATIO, 32'h0001_8000);
    for (i = 0; i < 4; i++) send_frame(16'(i * 9000 - 20000), 16'(15000 - i * 7000));
    wait_idle(SETTLE);

    // top of the range: most frames skipped while the position drains
    write_reg(REG_STEP_RATIO, 32'd524288);
    for (i = 0; i < 9; i++) send_frame(16'(i * 4000), 16'(-i * 3000));
    wait_idle(SETTLE);

    // above the range, upper data bits set
    write_reg(REG_STEP_RATIO, 32'hffff_ffff);
    for (i = 0; i < 4; i++) send_frame(16'(-i * 5000), 16'(i * 6000));
    wait_idle(SETTLE);

    // mono switch with a stereo previous frame still stored
    write_reg(REG_STEP_RATIO, 32'h0000_8000);
    write_reg(REG_MONO_MODE, 32'hffff_ffff);
    send_frame(16'sd30000, -16'sd30000);
    send_frame(-16'sd20000, 16'sd11111);
    wait_idle(SETTLE);
    write_reg(REG_MONO_MODE, 32'hffff_fffe);

    // random phases: no idling, sender gaps, result stalls, light both
    for (ph = 0; ph < PHASES; ph++) begin
      junk = $urandom();
      write_reg(REG_STEP_RATIO, {junk[31:STEP_W], pick_step()});
      junk = $urandom();
      write_reg(REG_MONO_MODE, junk);
      case (ph % 4)
        0: run_phase(PHASE_ITEMS, 0, 0);
        1: run_phase(PHASE_ITEMS, 61, 0);
        2: run_phase(PHASE_ITEMS, 0, 61);
        default: run_phase(PHASE_ITEMS, 7, 7);
      endcase
    end

    wait_idle(SETTLE);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("linear_interp_rate_converter regression: pass");
    end else begin
      $display("linear_interp_rate_converter regression: fail");
    end
    $finish;
  end

endmodule
